@@ rtl/core/psan_pkg.sv @@
// Shared types and constants for the path sanitizer stream unit.
// No dependencies; imported by every module of the block.
package psan_pkg;

    localparam logic [7:0]  SLASH         = 8'h2F;
    localparam logic [7:0]  DOT           = 8'h2E;
    localparam int          CAP_W         = 13;
    localparam logic [12:0] CAPACITY_RST  = 13'd128;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          CMD_BYTES     = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLASH = 2'd1,
        ST_DOT_DOT  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // One work record from front to back: up to four path bytes,
    // optionally followed by the closing item.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [2:0]                cnt;
        logic                      close;
        t_status                   status;
    } t_cmd;

endpackage

@@ rtl/core/psan_front.sv @@
// Front end: accepts path bytes, tracks per-path state, builds work records.
// Depends on psan_pkg.
module psan_front import psan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd
);

    logic [CAP_W-1:0] r_cap;
    logic             r_started, n_started;
    t_status          r_err, n_err;
    logic [1:0]       r_hcnt, n_hcnt;
    logic [7:0]       r_held [2];
    logic [7:0]       n_held0, n_held1;
    logic             r_pass, n_pass;
    logic             r_comp, n_comp;
    logic [CAP_W-1:0] r_len, n_len;

    logic             close_req;
    logic [1:0]       cl_cnt;
    logic [7:0]       cl_b0, cl_b1;
    logic             pre;
    logic [1:0]       bc;
    logic [7:0]       bb [3];
    logic [CMD_BYTES-1:0][7:0] cand;
    logic [2:0]       k, m;
    logic [3:0]       ok;

    always_comb begin
        n_started = r_started;
        n_err     = r_err;
        n_hcnt    = r_hcnt;
        n_held0   = r_held[0];
        n_held1   = r_held[1];
        n_pass    = r_pass;
        n_comp    = r_comp;
        close_req = 1'b0;
        cl_cnt    = r_hcnt;
        cl_b0     = r_held[0];
        cl_b1     = r_held[1];
        pre       = 1'b0;
        bc        = 2'd0;
        bb[0]     = 8'h00;
        bb[1]     = 8'h00;
        bb[2]     = 8'h00;

        priority if (!r_started) begin
            n_started = 1'b1;
            if (r_cap < 13'd2) begin
                n_err = ST_OVERFLOW;
            end else if (i_in_byte != SLASH) begin
                n_err = ST_NO_SLASH;
            end else begin
                bb[0] = SLASH;
                bc    = 2'd1;
            end
        end else if (r_err == ST_OK) begin
            priority if (i_in_byte == SLASH) begin
                close_req = 1'b1;
            end else if (r_pass) begin
                bb[0] = i_in_byte;
                bc    = 2'd1;
            end else if (r_hcnt < 2'd2) begin
                n_hcnt = r_hcnt + 2'd1;
                if (r_hcnt[0]) begin
                    n_held1 = i_in_byte;
                end else begin
                    n_held0 = i_in_byte;
                end
                // path ends inside a short component: resolve it now
                close_req = i_in_last;
                cl_cnt    = r_hcnt + 2'd1;
                cl_b0     = r_hcnt[0] ? r_held[0] : i_in_byte;
                cl_b1     = i_in_byte;
            end else begin
                // third byte: component is neither "." nor ".."
                pre    = r_comp;
                bb[0]  = r_held[0];
                bb[1]  = r_held[1];
                bb[2]  = i_in_byte;
                bc     = 2'd3;
                n_comp = 1'b1;
                n_hcnt = 2'd0;
                n_pass = 1'b1;
            end
        end else begin
            // errored path: remaining bytes are swallowed
        end

        if (close_req) begin
            priority if (r_pass) begin
                n_pass = 1'b0;
            end else if (cl_cnt == 2'd1) begin
                if (cl_b0 != DOT) begin
                    pre    = r_comp;
                    bb[0]  = cl_b0;
                    bc     = 2'd1;
                    n_comp = 1'b1;
                end
            end else if (cl_cnt == 2'd2) begin
                if (cl_b0 == DOT && cl_b1 == DOT) begin
                    n_err = ST_DOT_DOT;
                end else begin
                    pre    = r_comp;
                    bb[0]  = cl_b0;
                    bb[1]  = cl_b1;
                    bc     = 2'd2;
                    n_comp = 1'b1;
                end
            end else begin
                n_pass = r_pass;
            end
            n_hcnt = 2'd0;
        end

        if (pre) begin
            cand = {bb[2], bb[1], bb[0], SLASH};
        end else begin
            cand = {8'h00, bb[2], bb[1], bb[0]};
        end
        k = {1'b0, bc} + {2'b00, pre};

        // capacity check for each successive put
        for (int i = 0; i < 4; i++) begin
            ok[i] = ({1'b0, r_len} + 14'(i + 1)) < {1'b0, r_cap};
        end
        m = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < k && ok[i]) begin
                m = 3'(i + 1);
            end
        end
        if (m < k) begin
            n_err = ST_OVERFLOW;
        end
        n_len = r_len + {10'd0, m};

        o_cmd.data   = cand;
        o_cmd.cnt    = m;
        o_cmd.close  = i_in_last;
        o_cmd.status = n_err;
        o_cmd_valid  = i_accept && (m != 3'd0 || i_in_last);

        if (i_in_last) begin
            n_started = 1'b0;
            n_err     = ST_OK;
            n_hcnt    = 2'd0;
            n_pass    = 1'b0;
            n_comp    = 1'b0;
            n_len     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAPACITY_RST;
            r_started <= 1'b0;
            r_err     <= ST_OK;
            r_hcnt    <= 2'd0;
            r_pass    <= 1'b0;
            r_comp    <= 1'b0;
            r_len     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_started <= n_started;
                r_err     <= n_err;
                r_hcnt    <= n_hcnt;
                r_pass    <= n_pass;
                r_comp    <= n_comp;
                r_len     <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held[0] <= n_held0;
            r_held[1] <= n_held1;
        end
    end

endmodule

@@ rtl/core/psan_queue.sv @@
// Short queue of work records between front and back.
// Depends on psan_pkg.
module psan_queue import psan_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/psan_back.sv @@
// Back end: walks the head work record and presents one result item at a time.
// Depends on psan_pkg.
module psan_back import psan_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    input  logic       i_pop,
    output logic       o_head_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [1:0] o_status
);

    logic [2:0] r_idx;
    logic       on_close, done, take;

    assign o_empty  = !i_head_valid;
    assign on_close = (r_idx >= i_head.cnt);
    assign take     = i_pop && i_head_valid;
    assign done     = on_close || ((r_idx + 3'd1 == i_head.cnt) && !i_head.close);
    assign o_head_pop = take && done;

    always_comb begin
        if (on_close) begin
            o_out_byte = 8'h00;
            o_out_last = 1'b1;
            o_status   = i_head.status;
        end else begin
            o_out_byte = i_head.data[r_idx[1:0]];
            o_out_last = 1'b0;
            o_status   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (take) begin
            r_idx <= done ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

@@ rtl/core/path_sanitizer_stream_unit.sv @@
// Path sanitizer stream unit: one path byte per item in, cleaned path out.
// Each item's record is registered in the queue; its results show once it reaches the head.
// Flow: one item per cycle while the queue is not full and each item yields at most one
// result; an item with up to five results holds the back end while the 4-deep queue absorbs it.
// Reset: synchronous, active low; clears path state and queue, capacity returns to 128.
// Depends on psan_pkg, psan_front, psan_queue, psan_back.
module path_sanitizer_stream_unit import psan_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input side
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    // result side
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [1:0]       o_status,
    // capacity register
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    // The front resolves each item in the cycle it is taken: slash runs,
    // held "." / ".." bytes and the capacity check, producing a record of
    // bytes to emit plus an optional closing item.
    logic accept;
    logic cmd_valid;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic q_full, q_empty, q_pop;

    // full is conservative: it tracks the queue, even for items that
    // produce no result.
    assign full   = q_full;
    assign accept = push && !q_full;

    psan_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    // Records decouple the two sides so the front keeps taking bytes
    // while the back still drains a multi-byte record.
    psan_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd_in),
        .i_pop   (q_pop),
        .o_cmd   (cmd_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back walks the head record one result item per pop.
    psan_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (cmd_head),
        .i_pop        (pop),
        .o_head_pop   (q_pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_status     (o_status)
    );

    // closing item always carries a NUL byte
    a_close_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_last) |-> (o_out_byte == 8'h00))
        else $error("closing item carries a non-zero byte");

    // status is only meaningful on the closing item
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_last) |-> (o_status == ST_OK))
        else $error("status set on a path byte item");

    // front never produces a record while the queue is full
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |-> !q_full)
        else $error("work record produced into a full queue");

endmodule
